FILE: rtl/core/orq_pkg.sv
// Shared types, opcodes and status codes of the ordered ready queue.
package orq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 8;

   // Opcodes as they arrive on the request port.
   localparam logic [2:0] OPC_INSERT = 3'd0;
   localparam logic [2:0] OPC_POP    = 3'd1;
   localparam logic [2:0] OPC_REMOVE = 3'd2;
   localparam logic [2:0] OPC_DECR   = 3'd3;
   localparam logic [2:0] OPC_LOOKUP = 3'd4;

   // Status codes reported with every result.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;
   localparam logic [1:0] STAT_MISSING = 2'd3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [23:0] arrival_time;
      logic [7:0]  thread_id;
      logic [15:0] run_ticks;
   } req_type;

   typedef struct packed {
      logic        head_valid;
      logic [7:0]  head_thread;
      logic [23:0] head_time;
      logic [15:0] head_remaining;
      logic        found;
      logic [15:0] found_remaining;
      logic [4:0]  entry_count;
      logic [1:0]  status;
   } rsp_type;

   // Operation class decided by the front end.
   typedef enum logic [2:0] {
      OP_INSERT,
      OP_POP,
      OP_REMOVE,
      OP_DECR,
      OP_LOOKUP,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type  op;
      logic    scan;
      req_type req;
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_REPORT
   } state_type;

endpackage

FILE: rtl/core/orq_fifo.sv
// Two-entry queue of any packed type, used between the stages of the block.
module orq_fifo #(
   parameter type T = logic
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   output logic full,
   input  logic pop,
   output T     pop_data,
   output logic empty
);

   T           slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage for the waiting beats.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/orq_front.sv
// Front end: accepts request beats, classifies them and queues the commands.
module orq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  orq_pkg::req_type req_data,
   output logic             full,
   input  logic             cmd_take,
   output orq_pkg::cmd_type cmd,
   output logic             cmd_valid
);
   import orq_pkg::*;

   cmd_type cls;
   logic    cmd_empty;

   // Decode the opcode into an operation class and note whether it needs a walk.
   always_comb begin
      cls.req = req_data;
      unique case (req_data.opcode)
         OPC_INSERT: cls.op = OP_INSERT;
         OPC_POP:    cls.op = OP_POP;
         OPC_REMOVE: cls.op = OP_REMOVE;
         OPC_DECR:   cls.op = OP_DECR;
         OPC_LOOKUP: cls.op = OP_LOOKUP;
         default:    cls.op = OP_NONE;
      endcase
      cls.scan = (cls.op == OP_INSERT) || (cls.op == OP_REMOVE) || (cls.op == OP_LOOKUP);
   end

   orq_fifo #(.T(cmd_type)) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls),
      .full      (full),
      .pop       (cmd_take),
      .pop_data  (cmd),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/core/orq_back.sv
// Back end: holds the sorted entries and carries out one command at a time.
module orq_back #(
   parameter int QUEUE_DEPTH = orq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = orq_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  orq_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             rsp_room,
   output logic             rsp_push,
   output orq_pkg::rsp_type rsp
);
   import orq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // Entry storage, kept sorted from slot 0.
   logic [23:0]        e_time   [QUEUE_DEPTH];
   logic [ID_BITS-1:0] e_thread [QUEUE_DEPTH];
   logic [15:0]        e_left   [QUEUE_DEPTH];

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               hit_ff, hit_in;
   logic [15:0]        hitleft_ff, hitleft_in;
   logic [1:0]         status_ff, status_in;

   logic               do_ins, do_drop, do_dec;
   logic [CNT_W-1:0]   drop_pos;
   logic [23:0]        rd_time;
   logic [ID_BITS-1:0] rd_thread;
   logic [15:0]        rd_left;
   logic [ID_BITS-1:0] key_id;
   logic               match;

   // Entry under the walk pointer.
   assign rd_time   = e_time[idx_ff[IDX_W-1:0]];
   assign rd_thread = e_thread[idx_ff[IDX_W-1:0]];
   assign rd_left   = e_left[idx_ff[IDX_W-1:0]];
   assign key_id    = ID_BITS'(cmd_ff.req.thread_id);

   // Insert stops at the first later entry; remove and lookup at the first id match.
   always_comb begin
      if (cmd_ff.op == OP_INSERT) begin
         match = (rd_time > cmd_ff.req.arrival_time) ||
                 ((rd_time == cmd_ff.req.arrival_time) && (rd_thread > key_id));
      end else begin
         match = (rd_thread == key_id);
      end
   end

   // Sequencer: take a command, walk the entries, update, then report.
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      hit_in     = hit_ff;
      hitleft_in = hitleft_ff;
      status_in  = status_ff;
      cmd_take   = 1'b0;
      rsp_push   = 1'b0;
      do_ins     = 1'b0;
      do_drop    = 1'b0;
      do_dec     = 1'b0;
      drop_pos   = pos_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && rsp_room) begin
               cmd_take   = 1'b1;
               cmd_in     = cmd;
               idx_in     = '0;
               pos_in     = count_ff;
               hit_in     = 1'b0;
               hitleft_in = '0;
               state_in   = cmd.scan ? S_SCAN : S_APPLY;
            end
         end
         S_SCAN: begin
            if (idx_ff >= count_ff) begin
               state_in = S_APPLY;
            end else if (match) begin
               pos_in     = idx_ff;
               hit_in     = 1'b1;
               hitleft_in = rd_left;
               state_in   = S_APPLY;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_APPLY: begin
            status_in  = STAT_OK;
            hit_in     = 1'b0;
            hitleft_in = '0;
            state_in   = S_REPORT;
            unique case (cmd_ff.op)
               OP_INSERT: begin
                  if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     status_in = STAT_FULL;
                  end else begin
                     do_ins   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_POP: begin
                  drop_pos = '0;
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     do_drop  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  hit_in = hit_ff;
                  if (hit_ff) begin
                     do_drop  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     status_in = STAT_MISSING;
                  end
               end
               OP_DECR: begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     do_dec = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  hit_in     = hit_ff;
                  hitleft_in = hitleft_ff;
                  if (!hit_ff) begin
                     status_in = STAT_MISSING;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end
         S_REPORT: begin
            rsp_push = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      hit_ff     <= hit_in;
      hitleft_ff <= hitleft_in;
      status_ff  <= status_in;
   end

   // Entry moves: each slot takes its neighbor's value on a shift.
   always_ff @(posedge clock) begin
      if (do_ins) begin
         for (int j = 1; j < QUEUE_DEPTH; j++) begin
            if (CNT_W'(j) > pos_ff) begin
               e_time[j]   <= e_time[j-1];
               e_thread[j] <= e_thread[j-1];
               e_left[j]   <= e_left[j-1];
            end
         end
         for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (CNT_W'(j) == pos_ff) begin
               e_time[j]   <= cmd_ff.req.arrival_time;
               e_thread[j] <= key_id;
               e_left[j]   <= cmd_ff.req.run_ticks;
            end
         end
      end
      if (do_drop) begin
         for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            if (CNT_W'(j) >= drop_pos) begin
               e_time[j]   <= e_time[j+1];
               e_thread[j] <= e_thread[j+1];
               e_left[j]   <= e_left[j+1];
            end
         end
      end
      if (do_dec && (e_left[0] != '0)) begin
         e_left[0] <= e_left[0] - 16'd1;
      end
   end

   // Result beat built from the state after the operation.
   always_comb begin
      rsp.head_valid      = (count_ff != '0);
      rsp.head_thread     = rsp.head_valid ? 8'(e_thread[0]) : '0;
      rsp.head_time       = rsp.head_valid ? e_time[0] : '0;
      rsp.head_remaining  = rsp.head_valid ? e_left[0] : '0;
      rsp.found           = hit_ff;
      rsp.found_remaining = hitleft_ff;
      rsp.entry_count     = 5'(count_ff);
      rsp.status          = status_ff;
   end

endmodule

FILE: rtl/core/ordered_ready_queue_unit.sv
// Top level of the ordered ready queue: front end, back end and result queue.
//
// Request beats go in through push/full/req_data, one command per beat:
// insert, pop head, remove by id, decrement head or lookup by id.
// Every request gives exactly one result beat on rsp_data, seen while empty
// is low and taken with pop. A result carries the head entry, the entry
// count, the found flag and a status code after the operation.
// The front end classifies each beat into a two-entry command queue. The
// back end runs one command at a time: insert, remove and lookup walk the
// sorted entries one slot per cycle, while pop, decrement and unknown
// opcodes skip the walk. The back end takes no new command until it has
// reported the last one.
// Reset empties the queue and both beat queues; entry storage is not cleared.
// When the receiver stalls, results wait in a two-entry result queue, the
// back end holds off new commands, and full rises once the command queue
// fills.
module ordered_ready_queue_unit #(
   parameter int QUEUE_DEPTH = orq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = orq_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  orq_pkg::req_type req_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output orq_pkg::rsp_type rsp_data
);
   import orq_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;
   rsp_type rsp;
   logic    rsp_push;
   logic    rsp_full;

   orq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .cmd_valid (cmd_valid)
   );

   orq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_room  (!rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp)
   );

   // Result queue between the back end and the receiver.
   orq_fifo #(.T(rsp_type)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule
